>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; every property is clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define SSCR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sscr assertion failed");

// expression must never be true at a rising edge out of reset
`define SSCR_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("sscr forbidden condition seen");

`endif

>>> rtl/sscr_pkg.sv
// shared types for the sorted scan replacement block
// controller states and the command and status groups between controller and datapath
package sscr_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNLINK,
		ST_LINK,
		ST_WALK,
		ST_INS1,
		ST_INS2,
		ST_FINISH
	} state_t;

	// controller to datapath commands, at most one set per cycle
	typedef struct packed {
		logic accept;
		logic unlink;
		logic link_start;
		logic walk_step;
		logic ins1;
		logic ins2;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic head_null;
		logic stop;
		logic out_busy;
	} status_t;

endpackage

>>> rtl/sscr_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module sscr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sscr_ctrl.sv
// controller state machine for the sorted scan replacement block
// depends on sscr_pkg for states, commands and status
module sscr_ctrl import sscr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d = stat.full ? ST_UNLINK : ST_LINK;
				end
			end
			ST_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d = ST_LINK;
			end
			ST_LINK: begin
				cmd.link_start = 1'b1;
				state_d = stat.head_null ? ST_INS1 : ST_WALK;
			end
			ST_WALK: begin
				if (stat.stop) begin
					state_d = ST_INS1;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_INS1: begin
				cmd.ins1 = 1'b1;
				state_d = ST_INS2;
			end
			ST_INS2: begin
				cmd.ins2 = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// new transactions only between items
	assign req_stall = (state_q != ST_IDLE);

endmodule

>>> rtl/sscr_dp.sv
// datapath: link, prev and key memories, list head, scan pointer, fill count, result register
// depends on sscr_pkg and sscr_ram
module sscr_dp import sscr_pkg::*; #(
	parameter int SLOTS       = 64,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cmd_t                                    cmd,
	output status_t                                 stat,
	input  logic [OFFSET_BITS-1:0]                  req_offset,
	input  logic                                    res_stall,
	output logic                                    res_valid,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot,
	output logic                                    evicted,
	output logic [OFFSET_BITS-1:0]                  evicted_offset
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// list control registers
	logic [LW-1:0]          head_q;
	logic [LW-1:0]          scan_q;
	logic [LW-1:0]          fill_q;
	// per item working registers
	logic [OFFSET_BITS-1:0] key_q;
	logic [SW-1:0]          s_q;
	logic [LW-1:0]          cur_q;
	logic [LW-1:0]          x_q;
	logic [OFFSET_BITS-1:0] old_q;
	logic                   evicted_q;
	// result register
	logic                   res_valid_q;
	logic [SW-1:0]          slot_q;
	logic                   res_evicted_q;
	logic [OFFSET_BITS-1:0] res_old_q;

	// memory ports
	logic [SW-1:0]          rd_addr;
	logic [LW-1:0]          rd_next;
	logic [LW-1:0]          rd_prev;
	logic [OFFSET_BITS-1:0] rd_key;
	logic                   nxt_we;
	logic [SW-1:0]          nxt_waddr;
	logic [LW-1:0]          nxt_wdata;
	logic                   prv_we;
	logic [SW-1:0]          prv_waddr;
	logic [LW-1:0]          prv_wdata;
	logic                   key_we;

	logic [LW-1:0]          s_ext;
	logic [SW-1:0]          victim;
	logic [LW-1:0]          head_new;

	assign s_ext  = LW'(s_q);
	assign victim = (scan_q == NIL) ? '0 : scan_q[SW-1:0];
	// head after the victim leaves the list
	assign head_new = (s_ext == head_q) ? rd_next : head_q;

	// read address: victim on accept, head on link start, successor while walking
	always_comb begin
		rd_addr = head_q[SW-1:0];
		if (cmd.accept) begin
			rd_addr = victim;
		end else if (cmd.walk_step) begin
			rd_addr = rd_next[SW-1:0];
		end
	end

	// next link writes: unlink bypass, predecessor to new slot, new slot to successor
	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = rd_prev[SW-1:0];
		nxt_wdata = rd_next;
		if (cmd.unlink) begin
			nxt_we = (rd_prev != NIL);
		end else if (cmd.ins1) begin
			nxt_we    = (cur_q != NIL);
			nxt_waddr = cur_q[SW-1:0];
			nxt_wdata = s_ext;
		end else if (cmd.ins2) begin
			nxt_we    = 1'b1;
			nxt_waddr = s_q;
			nxt_wdata = x_q;
		end
	end

	// prev link writes, mirror of the next link writes
	always_comb begin
		prv_we    = 1'b0;
		prv_waddr = rd_next[SW-1:0];
		prv_wdata = rd_prev;
		if (cmd.unlink) begin
			prv_we = (rd_next != NIL);
		end else if (cmd.ins1) begin
			prv_we    = (x_q != NIL);
			prv_waddr = x_q[SW-1:0];
			prv_wdata = s_ext;
		end else if (cmd.ins2) begin
			prv_we    = 1'b1;
			prv_waddr = s_q;
			prv_wdata = cur_q;
		end
	end

	assign key_we = cmd.link_start;

	sscr_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (rd_addr),
		.rdata (rd_next)
	);

	sscr_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (rd_addr),
		.rdata (rd_prev)
	);

	sscr_ram #(.WIDTH(OFFSET_BITS), .DEPTH(SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (s_q),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (rd_key)
	);

	// head, scan pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			scan_q <= NIL;
			fill_q <= '0;
		end else begin
			if (cmd.accept && (fill_q != NIL)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.unlink) begin
				head_q <= head_new;
				scan_q <= (rd_next != NIL) ? rd_next : head_new;
			end
			if (cmd.link_start && (head_q == NIL)) begin
				scan_q <= s_ext;
			end
			if (cmd.ins1 && (cur_q == NIL)) begin
				head_q <= s_ext;
			end
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= req_offset;
			if (fill_q != NIL) begin
				s_q       <= fill_q[SW-1:0];
				evicted_q <= 1'b0;
				old_q     <= '0;
			end else begin
				s_q       <= victim;
				evicted_q <= 1'b1;
			end
		end
		if (cmd.unlink) begin
			old_q <= rd_key;
		end
		if (cmd.link_start) begin
			cur_q <= NIL;
			x_q   <= head_q;
		end
		if (cmd.walk_step) begin
			cur_q <= x_q;
			x_q   <= rd_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slot_q        <= s_q;
			res_evicted_q <= evicted_q;
			res_old_q     <= old_q;
		end
	end

	// status back to the controller
	assign stat.full      = (fill_q == NIL);
	assign stat.head_null = (head_q == NIL);
	assign stat.stop      = (x_q == NIL) || (rd_key > key_q);
	assign stat.out_busy  = res_valid_q && res_stall;

	assign res_valid      = res_valid_q;
	assign slot           = slot_q;
	assign evicted        = res_evicted_q;
	assign evicted_offset = res_old_q;

endmodule

>>> rtl/sorted_scan_cache_replacement.sv
// channel  | direction | handshake            | payload
// request  | in        | req_valid, req_stall | req_offset
// result   | out       | res_valid, res_stall | slot, evicted, evicted_offset
//
// one item at a time: ST_IDLE accepts, ST_UNLINK runs when all slots are used, ST_LINK
// starts the sorted walk, ST_WALK passes the list entries in order (up to SLOTS-1), ST_INS1
// and ST_INS2 relink, and ST_FINISH loads the result once the result register is free.
// the walk is bound by the single read port of the link and key memories.
// reset is asynchronous; no clearing pass, the fill count guards unwritten entries.
// a result waiting under res_stall holds the block in its last cycle only.
// top level of the sorted scan replacement block; instantiates sscr_ctrl and sscr_dp
module sorted_scan_cache_replacement import sscr_pkg::*; #(
	parameter int SLOTS       = 64,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    req_valid,
	output logic                                    req_stall,
	input  logic [OFFSET_BITS-1:0]                  req_offset,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot,
	output logic                                    evicted,
	output logic [OFFSET_BITS-1:0]                  evicted_offset
);

	cmd_t    cmd;
	status_t stat;

	sscr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sscr_dp #(.SLOTS(SLOTS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_offset     (req_offset),
		.res_stall      (res_stall),
		.res_valid      (res_valid),
		.slot           (slot),
		.evicted        (evicted),
		.evicted_offset (evicted_offset)
	);

endmodule

>>> rtl/sscr_checker.sv
// port level checks for the sorted scan replacement block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module sscr_checker #(
	parameter int SLOTS       = 64,
	parameter int OFFSET_BITS = 48
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    req_valid,
	input logic                                    req_stall,
	input logic                                    res_valid,
	input logic                                    res_stall,
	input logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot,
	input logic                                    evicted,
	input logic [OFFSET_BITS-1:0]                  evicted_offset
);

	// an accepted request keeps the block busy in the next cycle
	`SSCR_ASSERT(a_busy_after_req, (req_valid && !req_stall) |=> req_stall)

	// handshake outputs of the block are always driven to known values
	`SSCR_NEVER(a_handshake_known, $isunknown(req_stall) || $isunknown(res_valid))

	// a fresh slot reports no old offset
	`SSCR_NEVER(a_fresh_offset_zero, res_valid && !evicted && (evicted_offset != '0))

	// a stalled result transaction holds its slot
	`SSCR_ASSERT(a_res_hold, (res_valid && res_stall) |=> (res_valid && $stable(slot)))

endmodule

bind sorted_scan_cache_replacement sscr_checker #(
	.SLOTS       (SLOTS),
	.OFFSET_BITS (OFFSET_BITS)
) u_sscr_checker (.*);

>>> test/tb_sorted_scan_cache_replacement.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_scan_cache_replacement: a directed table, then random
// miss requests with bursty offers and patterned result stalls, checked by a built-in slot predictor
// depends only on rtl/sorted_scan_cache_replacement.sv and the blocks it instantiates
module tb_sorted_scan_cache_replacement;

	localparam int SLOTS        = 64;
	localparam int OFFSET_BITS  = 48;
	localparam int SLOT_W       = 6;
	localparam int RANDOM_ITEMS = 1630;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
	localparam logic [6:0] NIL  = 7'(SLOTS);

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [6:0]             link_t;

	// one grant: slot handed out and what it held before
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		offset_t           old_offset;
	} grant_t;

	// one request row; typed rows carry their grant written out by hand
	typedef struct packed {
		offset_t offset;
		logic    typed;
		grant_t  want;
	} row_t;

	// directed rows: list still filling, so slot follows the row and nothing is evicted
	localparam row_t DIR_ROWS [20] = '{
		{48'h8000_0000_0000, 1'b1, 6'd0,  1'b0, 48'h0},  // first entry into empty list
		{48'hFFFF_FFFF_FFFF, 1'b1, 6'd1,  1'b0, 48'h0},  // largest offset, new tail
		{48'h5555_5555_5555, 1'b1, 6'd2,  1'b0, 48'h0},  // smaller than head, new head
		{48'h5555_5555_5555, 1'b1, 6'd3,  1'b0, 48'h0},  // equal to head, goes after it
		{48'h0000_0000_0000, 1'b1, 6'd4,  1'b0, 48'h0},  // smallest offset, new head
		{48'hFFFF_FFFF_FFFF, 1'b1, 6'd5,  1'b0, 48'h0},  // equal to tail
		{48'h8000_0000_0000, 1'b1, 6'd6,  1'b0, 48'h0},  // equal in the middle
		{48'h0000_0000_0000, 1'b1, 6'd7,  1'b0, 48'h0},  // equal to head again
		{48'h0000_0000_0001, 1'b1, 6'd8,  1'b0, 48'h0},
		{48'h7FFF_FFFF_FFFF, 1'b1, 6'd9,  1'b0, 48'h0},
		{48'hAAAA_AAAA_AAAA, 1'b1, 6'd10, 1'b0, 48'h0},
		{48'hFFFF_FFFF_FFFE, 1'b1, 6'd11, 1'b0, 48'h0},
		{48'h0000_0000_1000, 1'b1, 6'd12, 1'b0, 48'h0},
		{48'h0000_0000_0800, 1'b1, 6'd13, 1'b0, 48'h0},
		{48'h0000_0000_0800, 1'b1, 6'd14, 1'b0, 48'h0},
		{48'h0123_4567_89AB, 1'b1, 6'd15, 1'b0, 48'h0},
		{48'hFEDC_BA98_7654, 1'b1, 6'd16, 1'b0, 48'h0},
		{48'h0000_0000_0001, 1'b1, 6'd17, 1'b0, 48'h0},
		{48'h0000_0000_0000, 1'b1, 6'd18, 1'b0, 48'h0},
		{48'hFFFF_FFFF_FFFF, 1'b1, 6'd19, 1'b0, 48'h0}
	};

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	offset_t           req_offset = '0;
	logic              res_stall  = 1'b0;
	logic              req_stall;
	logic              res_valid;
	logic [SLOT_W-1:0] slot;
	logic              evicted;
	offset_t           evicted_offset;

	// replacement state mirrored by the predictor
	link_t       nxt_of [SLOTS];
	link_t       prv_of [SLOTS];
	offset_t     key_of [SLOTS];
	link_t       head_slot;
	link_t       scan_slot;
	int unsigned used_slots;

	grant_t grant_q[$];
	row_t   pending_q[$];

	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_evicted;
	int unsigned n_errors;

	sorted_scan_cache_replacement #(
		.SLOTS      (SLOTS),
		.OFFSET_BITS(OFFSET_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_offset    (req_offset),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.slot          (slot),
		.evicted       (evicted),
		.evicted_offset(evicted_offset)
	);

	always #5 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#10_000_000;
		$display("timeout at %0t: %0d grants still awaited", $time, grant_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	// insert slot s after every entry whose offset is not above k
	function automatic void place_sorted(input link_t s, input offset_t k);
		link_t cur;
		link_t fol;
		if (head_slot == NIL) begin
			head_slot = s;
			scan_slot = s;
			prv_of[s] = NIL;
			nxt_of[s] = NIL;
			return;
		end
		cur = head_slot;
		if (key_of[cur] > k) begin
			prv_of[cur] = s;
			nxt_of[s]   = cur;
			prv_of[s]   = NIL;
			head_slot   = s;
			return;
		end
		fol = nxt_of[cur];
		while (fol != NIL && key_of[fol] <= k) begin
			cur = fol;
			fol = nxt_of[cur];
		end
		nxt_of[cur] = s;
		prv_of[s]   = cur;
		nxt_of[s]   = fol;
		if (fol != NIL)
			prv_of[fol] = s;
	endfunction

	// pick the slot for one miss, evicting under the scan pointer once full
	function automatic grant_t choose_slot(input offset_t k);
		grant_t g;
		link_t  s;
		link_t  p;
		link_t  n;
		g = '0;
		if (used_slots < SLOTS) begin
			s = link_t'(used_slots);
			used_slots++;
		end else begin
			s = (scan_slot == NIL) ? 7'd0 : scan_slot;
			g.evicted    = 1'b1;
			g.old_offset = key_of[s];
			if (s == head_slot)
				head_slot = nxt_of[s];
			scan_slot = (nxt_of[s] != NIL) ? nxt_of[s] : head_slot;
			// unlink, skipping missing neighbors at the list ends
			p = prv_of[s];
			n = nxt_of[s];
			if (p != NIL)
				nxt_of[p] = n;
			if (n != NIL)
				prv_of[n] = p;
			prv_of[s] = NIL;
			nxt_of[s] = NIL;
		end
		key_of[s] = k;
		place_sorted(s, k);
		g.slot = s[SLOT_W-1:0];
		return g;
	endfunction

	// offsets: wide values, dense small ones for ties, extremes and repeats
	function automatic offset_t pick_offset(input offset_t recent);
		offset_t wide;
		wide = offset_t'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1:    return wide;
			2, 3, 4: return offset_t'($urandom_range(0, 40));
			5:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
			6:       return recent;
			7:       return recent + offset_t'($urandom_range(0, 6)) - offset_t'(3);
			default: return wide >> $urandom_range(0, OFFSET_BITS - 1);
		endcase
	endfunction

	// offer one request and hold it until the block takes it
	task automatic offer(input row_t row);
		pending_q.push_back(row);
		req_valid  <= 1'b1;
		req_offset <= row.offset;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// predict on every accepted request, check every accepted grant
	always @(posedge clk) begin : monitor
		row_t   row;
		grant_t want;
		grant_t due;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				row  = pending_q.pop_front();
				want = choose_slot(req_offset);
				if (row.typed)
					want = row.want;
				grant_q.push_back(want);
			end
			if (res_valid && !res_stall) begin
				n_checked++;
				if (evicted)
					n_evicted++;
				if (grant_q.size() == 0) begin
					n_errors++;
					$display("%0t: grant with none awaited: slot %0d evicted %0b offset %h",
						$time, slot, evicted, evicted_offset);
				end else begin
					due = grant_q.pop_front();
					if (slot !== due.slot) begin
						n_errors++;
						$display("%0t: slot expected %0d actual %0d", $time, due.slot, slot);
					end
					if (evicted !== due.evicted) begin
						n_errors++;
						$display("%0t: evicted expected %0b actual %0b",
							$time, due.evicted, evicted);
					end
					if (evicted_offset !== due.old_offset) begin
						n_errors++;
						$display("%0t: evicted_offset expected %h actual %h",
							$time, due.old_offset, evicted_offset);
					end
				end
			end
		end
	end

	// result side: stall modes of random length, plus one long hold-off
	initial begin : receiver
		int unsigned span;
		int unsigned mode;
		int unsigned tick;
		bit          held;
		held = 1'b0;
		tick = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
					0:       res_stall <= 1'b0;
					1:       res_stall <= ($urandom_range(0, 3) == 0);
					2:       res_stall <= ($urandom_range(0, 1) == 1);
					default: res_stall <= ((tick % 5) < 2);
				endcase
			end
			// block fills up and stalls its input while the sender keeps offering
			if (!held && n_checked >= 300) begin
				held = 1'b1;
				@(posedge clk);
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// request side: reset, directed table, then random bursts
	initial begin : stimulus
		row_t        row;
		offset_t     recent;
		int unsigned burst;
		for (int i = 0; i < SLOTS; i++) begin
			nxt_of[i] = NIL;
			prv_of[i] = NIL;
			key_of[i] = '0;
		end
		head_slot  = NIL;
		scan_slot  = NIL;
		used_slots = 0;
		n_sent     = 0;
		n_checked  = 0;
		n_evicted  = 0;
		n_errors   = 0;
		recent     = '0;
		burst      = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, with short gaps now and then
		foreach (DIR_ROWS[i]) begin
			offer(DIR_ROWS[i]);
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 5));
		end

		// random requests in bursts
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				// let the block drain completely once
				pause_sender(1);
				while (grant_q.size() != 0)
					@(posedge clk);
			end
			if (burst == 0) begin
				burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 15));
			end
			burst--;
			row        = '0;
			row.offset = pick_offset(recent);
			recent     = row.offset;
			offer(row);
		end

		// wait out the last grants
		pause_sender(1);
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (grant_q.size() != 0 || pending_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d grants never arrived", $time, grant_q.size());
		end
		$display("covered %0d miss requests, %0d grants checked, %0d of them evictions",
			n_sent, n_checked, n_evicted);
		$display("including ties, list-end inserts, one long result hold-off, %0d mismatches",
			n_errors);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
